FILE: rtl/development_index_heading_day_defines.svh
// Assertion macros used by the asserting top-level file
`ifndef DEVELOPMENT_INDEX_HEADING_DAY_DEFINES_SVH
`define DEVELOPMENT_INDEX_HEADING_DAY_DEFINES_SVH

// a |-> b, checked on every rising edge out of reset
`define DIHD_ASSERT_IMP(label, a, b) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (b)) \
        else $error("%s", "assertion failed");

// a |=> b
`define DIHD_ASSERT_NXT(label, a, b) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (b)) \
        else $error("%s", "assertion failed");

`endif

FILE: rtl/dihd_pkg.sv
`timescale 1ns / 1ps
package dihd_pkg;

    localparam int MaxDays = 1024;
    localparam int DayW    = 11;
    localparam int CfgIdxW = 3;

    localparam logic [CfgIdxW-1:0] CFG_RATE_SCALE = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_TEMP_MID   = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_CRIT_DL    = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_TEMP_SLOPE = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_PHOTO_SLOPE = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_INDEX_GATE = 3'd5;

    typedef struct packed {
        logic signed [15:0] temperature;
        logic [12:0]        daylength;
        logic               last_day;
    } t_in;

    typedef struct packed {
        logic [DayW-1:0] heading_day;
        logic            reached;
    } t_out;

    // Front to back: classified day
    typedef struct packed {
        logic signed [15:0] temperature;
        logic [12:0]        daylength;
        logic               last_day;
        logic               skip;     // series already finished
    } t_job;

    typedef enum logic [3:0] {
        S_IDLE, S_PX, S_PEXP, S_ZX, S_ZEXP, S_DIV, S_A, S_RATE, S_ACC, S_EMIT
    } t_state;

    typedef enum logic [2:0] {
        E_MUL, E_N, E_M1, E_M2, E_M3, E_SH
    } t_exp_step;

endpackage

FILE: rtl/dihd_front.sv
`timescale 1ns / 1ps
// Accepts day records into a two-deep queue and tags days of a finished series.
module dihd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dihd_pkg::t_in  i_item,
    output logic           o_full,
    input  logic           i_finished_set,  // back reports reached, not last
    input  logic           i_take,
    output logic           o_valid,
    output dihd_pkg::t_job o_job
);
    dihd_pkg::t_in r_q [2];
    logic [1:0]    r_cnt, n_cnt;
    logic          r_rd, r_wr;
    logic          r_fin;

    wire do_push = i_push && !o_full;
    wire do_pop  = i_take && o_valid;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);

    always_comb begin
        o_job.temperature = r_q[r_rd].temperature;
        o_job.daylength   = r_q[r_rd].daylength;
        o_job.last_day    = r_q[r_rd].last_day;
        o_job.skip        = r_fin;
        n_cnt = r_cnt + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wr] <= i_item;
        end
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_fin <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) r_wr <= ~r_wr;
            if (do_pop)  r_rd <= ~r_rd;
            if (i_finished_set) r_fin <= 1'b1;
            else if (do_pop && r_fin && r_q[r_rd].last_day) r_fin <= 1'b0;
        end
    end
endmodule

FILE: rtl/dihd_back.sv
`timescale 1ns / 1ps
// Rate sequencer: one shared multiplier, exp unit steps, bit-serial divider.
module dihd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  dihd_pkg::t_job  i_job,
    output logic            o_take,
    output logic            o_finished_set,
    input  logic [15:0]     i_rate_scale,
    input  logic signed [15:0] i_temp_mid,
    input  logic [12:0]     i_crit_dl,
    input  logic signed [15:0] i_temp_slope,
    input  logic signed [15:0] i_photo_slope,
    input  logic [16:0]     i_index_gate,
    input  logic            i_out_room,
    output logic            o_out_wr,
    output dihd_pkg::t_out  o_out
);
    dihd_pkg::t_state    r_st, n_st;
    dihd_pkg::t_exp_step r_es, n_es;
    dihd_pkg::t_job      r_job;
    logic signed [31:0]  r_dev;
    logic [dihd_pkg::DayW-1:0] r_day;
    logic signed [40:0]  r_arg;     // exponent argument 16.16
    logic signed [40:0]  r_y;
    logic signed [24:0]  r_n;
    logic [15:0]         r_f;
    logic [32:0]         r_m;
    logic [31:0]         r_p_exp;   // exp(x)
    logic [31:0]         r_e;       // exp(-z)
    logic [32:0]         r_q;       // quotient
    logic [33:0]         r_rem;
    logic [5:0]          r_cnt;
    logic signed [47:0]  r_a;
    logic signed [63:0]  r_rate;
    logic                r_emit_reach;
    logic [dihd_pkg::DayW-1:0] r_emit_day;
    logic                r_last_pend;

    // shared 34x34 signed multiplier
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic signed [40:0] y_sh;
    logic [33:0] divisor;
    logic [33:0] rem_sh;
    logic signed [63:0] sum;
    logic [31:0] exp_res;
    logic [63:0] mshl;

    assign divisor = 34'd65536 + {2'b0, r_e};
    assign rem_sh  = {r_rem[32:0], (r_cnt == 6'd32)};

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_st)
            dihd_pkg::S_PX: begin
                mul_a = 34'(i_photo_slope);
                mul_b = 34'($signed({1'b0, r_job.daylength}) - $signed({1'b0, i_crit_dl}));
            end
            dihd_pkg::S_ZX: begin
                mul_a = 34'(i_temp_slope);
                mul_b = 34'($signed(r_job.temperature) - $signed(i_temp_mid));
            end
            dihd_pkg::S_PEXP, dihd_pkg::S_ZEXP: begin
                case (r_es)
                    dihd_pkg::E_MUL: begin
                        mul_a = 34'(r_arg[31:0] == r_arg[31:0] ? r_arg : r_arg);
                        mul_b = 34'sd94548;
                    end
                    dihd_pkg::E_M1: begin
                        mul_a = {18'b0, r_f};
                        mul_b = 34'sd43047;
                    end
                    dihd_pkg::E_M2: begin
                        mul_a = {18'b0, r_f};
                        mul_b = {18'b0, r_f};
                    end
                    dihd_pkg::E_M3: begin
                        mul_a = 34'(r_rem[15:0]);
                        mul_b = 34'sd22489;
                    end
                    default: ;
                endcase
            end
            dihd_pkg::S_A: begin
                mul_a = {18'b0, i_rate_scale};
                mul_b = 34'sd65536 - 34'(r_p_exp);
            end
            dihd_pkg::S_RATE: begin
                mul_a = 34'(r_a);
                mul_b = {1'b0, r_q};
            end
            default: ;
        endcase
    end

    always_comb begin
        y_sh = r_y >>> 16;
        mshl = 64'(r_m) << r_n[3:0];
        if (r_n >= 25'sd15) exp_res = 32'h7FFF_FFFF;
        else if (r_n >= 0) exp_res = (mshl > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mshl[31:0];
        else if (r_n <= -25'sd18) exp_res = '0;
        else exp_res = 32'(r_m >> 5'(-r_n));
        sum = 64'(r_dev) + r_rate;
    end

    always_comb begin
        n_st = r_st;
        n_es = r_es;
        o_take = 1'b0;
        o_out_wr = 1'b0;
        o_out.heading_day = r_emit_day;
        o_out.reached = r_emit_reach;
        o_finished_set = 1'b0;
        case (r_st)
            dihd_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_take = 1'b1;
                    if (!i_job.skip) n_st = dihd_pkg::S_PX;
                end
            end
            dihd_pkg::S_PX: begin
                n_st = (r_dev >= $signed({15'b0, i_index_gate}) &&
                        r_job.daylength < i_crit_dl) ? dihd_pkg::S_PEXP : dihd_pkg::S_ACC;
                n_es = dihd_pkg::E_MUL;
            end
            dihd_pkg::S_PEXP, dihd_pkg::S_ZEXP: begin
                case (r_es)
                    dihd_pkg::E_MUL: n_es = dihd_pkg::E_N;
                    dihd_pkg::E_N:   n_es = dihd_pkg::E_M1;
                    dihd_pkg::E_M1:  n_es = dihd_pkg::E_M2;
                    dihd_pkg::E_M2:  n_es = dihd_pkg::E_M3;
                    dihd_pkg::E_M3:  n_es = dihd_pkg::E_SH;
                    default: begin
                        n_st = (r_st == dihd_pkg::S_PEXP) ? dihd_pkg::S_ZX : dihd_pkg::S_DIV;
                    end
                endcase
            end
            dihd_pkg::S_ZX: begin
                n_st = dihd_pkg::S_ZEXP;
                n_es = dihd_pkg::E_MUL;
            end
            dihd_pkg::S_DIV:  if (r_cnt == 6'd0) n_st = dihd_pkg::S_A;
            dihd_pkg::S_A:    n_st = dihd_pkg::S_RATE;
            dihd_pkg::S_RATE: n_st = dihd_pkg::S_ACC;
            dihd_pkg::S_ACC:  n_st = dihd_pkg::S_EMIT;
            dihd_pkg::S_EMIT: begin
                if (r_emit_reach || r_last_pend) begin
                    if (i_out_room) begin
                        o_out_wr = 1'b1;
                        o_finished_set = r_emit_reach && !r_job.last_day;
                        n_st = dihd_pkg::S_IDLE;
                    end
                end else begin
                    n_st = dihd_pkg::S_IDLE;
                end
            end
            default: n_st = dihd_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            dihd_pkg::S_IDLE: begin
                r_job  <= i_job;
                r_rate <= '0;
            end
            dihd_pkg::S_PX, dihd_pkg::S_ZX: begin
                r_arg <= (r_st == dihd_pkg::S_ZX) ? -41'(mul_p >>> 4) : 41'(mul_p >>> 4);
            end
            dihd_pkg::S_PEXP, dihd_pkg::S_ZEXP: begin
                case (r_es)
                    dihd_pkg::E_MUL: r_y <= 41'(mul_p >>> 16);
                    dihd_pkg::E_N: begin
                        r_n <= 25'(y_sh);
                        r_f <= r_y[15:0];
                    end
                    dihd_pkg::E_M1: r_m <= 33'd65536 + 33'(mul_p[31:16]);
                    dihd_pkg::E_M2: r_rem <= 34'(mul_p[31:16]);
                    dihd_pkg::E_M3: r_m <= r_m + 33'(mul_p[31:16]);
                    default: begin
                        if (r_st == dihd_pkg::S_PEXP) r_p_exp <= exp_res;
                        else begin
                            r_e   <= exp_res;
                            r_rem <= '0;
                            r_q   <= '0;
                            r_cnt <= 6'd32;
                        end
                    end
                endcase
            end
            dihd_pkg::S_DIV: begin
                // restoring division of 2^32, one bit a cycle
                if (rem_sh >= divisor) begin
                    r_rem <= rem_sh - divisor;
                    r_q   <= {r_q[31:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_q   <= {r_q[31:0], 1'b0};
                end
                if (r_cnt != 6'd0) r_cnt <= r_cnt - 6'd1;
            end
            dihd_pkg::S_A:    r_a <= 48'(mul_p >>> 16);
            dihd_pkg::S_RATE: r_rate <= 64'(mul_p >>> 16);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= dihd_pkg::S_IDLE;
            r_es  <= dihd_pkg::E_MUL;
            r_dev <= '0;
            r_day <= '0;
            r_emit_reach <= 1'b0;
            r_last_pend  <= 1'b0;
            r_emit_day   <= '0;
        end else begin
            r_st <= n_st;
            r_es <= n_es;
            if (r_st == dihd_pkg::S_ACC) begin
                if (sum > 64'sh7FFF_FFFF) r_dev <= 32'sh7FFF_FFFF;
                else if (sum < -64'sh8000_0000) r_dev <= 32'sh8000_0000;
                else r_dev <= sum[31:0];
                r_last_pend <= r_job.last_day;
                if (sum > 64'sd65536) begin
                    r_emit_reach <= 1'b1;
                    r_emit_day   <= r_day;
                end else begin
                    r_emit_reach <= 1'b0;
                    if (r_day < dihd_pkg::DayW'(dihd_pkg::MaxDays)) begin
                        r_emit_day <= r_day + 1'b1;
                        r_day      <= r_day + 1'b1;
                    end else begin
                        r_emit_day <= r_day;
                    end
                end
            end
            if (o_out_wr && (r_job.last_day || r_emit_reach)) begin
                if (r_job.last_day) begin
                    r_dev <= '0;
                    r_day <= '0;
                end
            end
            if (r_st == dihd_pkg::S_IDLE && i_valid && i_job.skip && i_job.last_day) begin
                r_dev <= '0;
                r_day <= '0;
            end
        end
    end
endmodule

FILE: rtl/development_index_heading_day.sv
// Heading-day detector for a daily development index.
// Input side looks like a queue: push a day record (temperature, daylength,
// last-day mark) when full is low. Results come out of a one-entry output
// queue: read heading_day/reached while empty is low, pop to take the beat.
// Configuration: cfg valid/ready with register index 0..5; write only when idle.
// A front queue of two records decouples input from the rate sequencer.
// Each active day runs through: take, photoperiod argument, exp (6 steps),
// temperature argument, exp (6 steps), bit-serial division for the
// logistic, two multiplies, the accumulate and the write-out; the sequencer
// takes the next day only after the write-out of the current one.
// Days outside the gate or daylength window go on from the photoperiod argument
// to the accumulate; days after the heading day of a finished series are only taken.
// One beat is produced at the first day the index exceeds one (reached=1), or
// at the last day of a series (reached=0, series length).
// Reset restores register defaults and clears index, day count and queues.
// If the receiver stalls, the output entry holds and the sequencer waits;
// the front queue keeps accepting until it fills.
`timescale 1ns / 1ps
`include "development_index_heading_day_defines.svh"
module development_index_heading_day (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            push,
    output logic            full,
    input  dihd_pkg::t_in   i_item,
    output logic            empty,
    input  logic            pop,
    output dihd_pkg::t_out  o_item,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [dihd_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [16:0]     i_cfg_data
);
    logic [15:0]        r_rate_scale;
    logic signed [15:0] r_temp_mid;
    logic [12:0]        r_crit_dl;
    logic signed [15:0] r_temp_slope;
    logic signed [15:0] r_photo_slope;
    logic [16:0]        r_index_gate;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_scale  <= 16'd655;
            r_temp_mid    <= '0;
            r_crit_dl     <= 13'd3328;
            r_temp_slope  <= 16'sd4096;
            r_photo_slope <= 16'sd4096;
            r_index_gate  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dihd_pkg::CFG_RATE_SCALE:  r_rate_scale  <= i_cfg_data[15:0];
                dihd_pkg::CFG_TEMP_MID:    r_temp_mid    <= i_cfg_data[15:0];
                dihd_pkg::CFG_CRIT_DL:     r_crit_dl     <= i_cfg_data[12:0];
                dihd_pkg::CFG_TEMP_SLOPE:  r_temp_slope  <= i_cfg_data[15:0];
                dihd_pkg::CFG_PHOTO_SLOPE: r_photo_slope <= i_cfg_data[15:0];
                dihd_pkg::CFG_INDEX_GATE:  r_index_gate  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic           job_valid, job_take, fin_set, out_wr;
    dihd_pkg::t_job job;
    dihd_pkg::t_out res;
    dihd_pkg::t_out r_out;
    logic           r_full_out;

    dihd_front u_front (
        .i_clk, .i_rst_n, .i_push(push), .i_item, .o_full(full),
        .i_finished_set(fin_set), .i_take(job_take), .o_valid(job_valid), .o_job(job)
    );

    dihd_back u_back (
        .i_clk, .i_rst_n, .i_valid(job_valid), .i_job(job), .o_take(job_take),
        .o_finished_set(fin_set),
        .i_rate_scale(r_rate_scale), .i_temp_mid(r_temp_mid), .i_crit_dl(r_crit_dl),
        .i_temp_slope(r_temp_slope), .i_photo_slope(r_photo_slope),
        .i_index_gate(r_index_gate),
        .i_out_room(!r_full_out || pop), .o_out_wr(out_wr), .o_out(res)
    );

    // output entry
    always_ff @(posedge i_clk) begin
        if (out_wr) r_out <= res;
        if (!i_rst_n) r_full_out <= 1'b0;
        else if (out_wr) r_full_out <= 1'b1;
        else if (pop) r_full_out <= 1'b0;
    end

    assign empty  = !r_full_out;
    assign o_item = r_out;

    `DIHD_ASSERT_IMP(a_wr_room, out_wr, !r_full_out || pop)
    `DIHD_ASSERT_NXT(a_wr_shows, out_wr, !empty)
endmodule
